### design/pfl_pkg.sv
// Shared types and constants for the page free-list allocator.
// Used by pfl_ctrl, pfl_datapath and page_free_list_allocator; depends on nothing.
package pfl_pkg;

    // Fixed field widths of the request and result ports.
    localparam int ID_W     = 10;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 10;
    localparam int COUNT_W  = 11;

    // Default number of page ids, page 0 included.
    localparam int MAX_PAGES_DEF = 1024;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and issue the memory reads
        logic commit;   // apply the update and load the result register
    } pfl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_hold; // result register is full and stalled
    } pfl_sts_t;

endpackage

### design/page_free_list_allocator.sv
// Page free-list allocator: one result per request. A request is captured with
// its registered link/mark read; the head, counters and result register are
// updated when it commits, which a stalled result delays. A new request is
// taken only after the last one has committed. A stalled result holds the next
// request until it is taken. Reset empties the list, sets the page total to 1
// and needs no clearing pass: a free mark is used only for pages below the
// total, and each is written when the total grows over it.
module page_free_list_allocator
    import pfl_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [ID_W-1:0]     page_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     granted_id,
    output logic [STATUS_W-1:0] status,
    output logic [FREE_W-1:0]   free_count,
    output logic [COUNT_W-1:0]  pages_used
);

    pfl_cmd_t cmd;
    pfl_sts_t sts;

    // Sequencing of capture and commit.
    pfl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Memories, list state and result register.
    pfl_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .page_id    (page_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted_id (granted_id),
        .status     (status),
        .free_count (free_count),
        .pages_used (pages_used)
    );

endmodule

### design/pfl_ctrl.sv
// Controller state machine of the page free-list allocator.
// Depends on pfl_pkg for the command and status structs.
module pfl_ctrl
    import pfl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pfl_sts_t sts,
    output pfl_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // A request is taken only when no request is in flight.
    assign in_stall    = (state_reg != ST_IDLE);
    assign cmd.capture = in_valid && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_EXEC) && !sts.out_hold;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/pfl_datapath.sv
// Datapath of the page free-list allocator: link and mark memories, list head,
// counters and the result register. Depends on pfl_pkg.
module pfl_datapath
    import pfl_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pfl_cmd_t            cmd,
    output pfl_sts_t            sts,
    input  logic                opcode,
    input  logic [ID_W-1:0]     page_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [ID_W-1:0]     granted_id,
    output logic [STATUS_W-1:0] status,
    output logic [FREE_W-1:0]   free_count,
    output logic [COUNT_W-1:0]  pages_used
);

    localparam int IdW  = $clog2(MAX_PAGES);
    localparam int CntW = IdW + 1;
    localparam int CmpW = (CntW > ID_W) ? CntW : ID_W;

    // Link and free-mark memories.
    logic [IdW-1:0] link_mem [MAX_PAGES];
    logic           mark_mem [MAX_PAGES];

    // Captured request and registered memory reads.
    logic           op_reg;
    logic [ID_W-1:0] id_reg;
    logic [IdW-1:0] link_rd_reg;
    logic           mark_rd_reg;

    // List and counter state.
    logic [IdW-1:0]  head_reg;
    logic [IdW-1:0]  head_next;
    logic [CntW-1:0] page_total_reg;
    logic [CntW-1:0] page_total_next;
    logic [IdW-1:0]  free_total_reg;
    logic [IdW-1:0]  free_total_next;

    // Result register.
    logic                out_valid_reg;
    logic [ID_W-1:0]     granted_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FREE_W-1:0]   free_count_reg;
    logic [COUNT_W-1:0]  pages_used_reg;

    // Update results for the captured request.
    logic [IdW-1:0]      granted_next;
    logic [STATUS_W-1:0] status_next;
    logic                link_we;
    logic [IdW-1:0]      link_waddr;
    logic [IdW-1:0]      link_wdata;
    logic                mark_we;
    logic [IdW-1:0]      mark_waddr;
    logic                mark_wdata;

    logic [CmpW-1:0] in_ext;
    logic [IdW-1:0]  in_idx;
    logic [CmpW-1:0] id_ext;
    logic [IdW-1:0]  id_idx;

    assign in_ext = CmpW'(page_id);
    assign in_idx = in_ext[IdW-1:0];
    assign id_ext = CmpW'(id_reg);
    assign id_idx = id_ext[IdW-1:0];

    assign sts.out_hold = out_valid_reg && out_stall;

    // Request capture and memory reads, issued in the accept cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            id_reg      <= page_id;
            link_rd_reg <= link_mem[head_reg];
            mark_rd_reg <= mark_mem[in_idx];
        end
    end

    // Memory writes, applied when the request commits.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.commit && mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
    end

    // Allocate or free decision on the registered reads.
    always_comb
    begin
        head_next       = head_reg;
        page_total_next = page_total_reg;
        free_total_next = free_total_reg;
        granted_next    = '0;
        status_next     = STATUS_OK;
        link_we         = 1'b0;
        link_waddr      = id_idx;
        link_wdata      = head_reg;
        mark_we         = 1'b0;
        mark_waddr      = id_idx;
        mark_wdata      = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            if (head_reg != '0)
            begin
                // Pop the head of the free list.
                granted_next    = head_reg;
                head_next       = link_rd_reg;
                free_total_next = free_total_reg - IdW'(1);
                mark_we         = 1'b1;
                mark_waddr      = head_reg;
            end
            else if (page_total_reg >= CntW'(MAX_PAGES))
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                // Grow the store by one page; its mark is cleared here, so every
                // page below the total has a written mark.
                granted_next    = page_total_reg[IdW-1:0];
                page_total_next = page_total_reg + CntW'(1);
                mark_we         = 1'b1;
                mark_waddr      = page_total_reg[IdW-1:0];
            end
        end
        else
        begin
            if ((id_ext == '0) || (id_ext >= CmpW'(page_total_reg)))
            begin
                status_next = STATUS_RANGE;
            end
            else if (mark_rd_reg)
            begin
                status_next = STATUS_DOUBLE;
            end
            else
            begin
                // Push the page onto the free list.
                link_we         = 1'b1;
                mark_we         = 1'b1;
                mark_wdata      = 1'b1;
                head_next       = id_idx;
                free_total_next = free_total_reg + IdW'(1);
            end
        end
    end

    // List head and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            page_total_reg <= CntW'(1);
            free_total_reg <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg       <= head_next;
            page_total_reg <= page_total_next;
            free_total_reg <= free_total_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            granted_reg    <= ID_W'(granted_next);
            status_reg     <= status_next;
            free_count_reg <= FREE_W'(free_total_next);
            pages_used_reg <= COUNT_W'(page_total_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign granted_id = granted_reg;
    assign status     = status_reg;
    assign free_count = free_count_reg;
    assign pages_used = pages_used_reg;

    // A commit never overwrites a result that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // The page total never shrinks.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (page_total_reg >= $past(page_total_reg)))
        else $error("page total decreased");

    // Free pages are a subset of the pages in use, page 0 excluded.
    assert property (@(posedge clk) disable iff (!rst_n)
        CntW'(free_total_reg) < page_total_reg)
        else $error("free count not below page total");

    // The list is empty exactly when the free count is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == '0) == (free_total_reg == '0))
        else $error("list head and free count disagree");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the page free-list allocator (page_free_list_allocator).
// Depends on pfl_pkg for field widths, opcodes and status codes; it reads no files.
// A scoreboard class predicts every result, and plain tasks drive random traffic.
module tb_top
    import pfl_pkg::*;
();

    localparam int MAX_PAGES    = MAX_PAGES_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int LATENCY      = 2;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    // One predicted result transaction.
    typedef struct {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] st;
        logic [FREE_W-1:0]   free_n;
        logic [COUNT_W-1:0]  pages;
    } grant_t;

    // Scoreboard: keeps its own copy of the free list and the expected results.
    class page_book;
        logic [ID_W-1:0]    link_of [MAX_PAGES];
        bit                 on_list [MAX_PAGES];
        logic [ID_W-1:0]    head;
        logic [COUNT_W-1:0] total;
        logic [FREE_W-1:0]  listed;
        grant_t             pending_grants[$];
        int unsigned        mismatch_count;

        function new();
            foreach (link_of[i])
            begin
                link_of[i] = '0;
                on_list[i] = 1'b0;
            end
            head           = '0;
            total          = COUNT_W'(1);
            listed         = '0;
            mismatch_count = 0;
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void log_request(logic op, logic [ID_W-1:0] id);
            grant_t g;
            g.id = '0;
            g.st = STATUS_OK;
            if (op == OP_ALLOC)
            begin
                if (head != '0)
                begin
                    // Pop the head of the free list.
                    g.id          = head;
                    head          = link_of[g.id];
                    on_list[g.id] = 1'b0;
                    if (listed != '0)
                        listed = listed - FREE_W'(1);
                end
                else if (total >= COUNT_W'(MAX_PAGES))
                    g.st = STATUS_FULL;
                else
                begin
                    // Empty list: grow the page total and hand out the new id.
                    g.id                     = total[ID_W-1:0];
                    on_list[total[ID_W-1:0]] = 1'b0;
                    total                    = total + COUNT_W'(1);
                end
            end
            else
            begin
                if (id == '0 || COUNT_W'(id) >= total)
                    g.st = STATUS_RANGE;
                else if (on_list[id])
                    g.st = STATUS_DOUBLE;
                else
                begin
                    link_of[id] = head;
                    on_list[id] = 1'b1;
                    head        = id;
                    listed      = listed + FREE_W'(1);
                end
            end
            g.free_n = listed;
            g.pages  = total;
            pending_grants.push_back(g);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            if (mismatch_count < PRINT_LIMIT)
                $display("tb_top: mismatch in %s: got %0d, expected %0d", what, got, want);
            mismatch_count++;
        endtask

        // Compare one accepted result transaction with the oldest prediction.
        task check_grant(logic [ID_W-1:0] id, logic [STATUS_W-1:0] st,
                         logic [FREE_W-1:0] free_n, logic [COUNT_W-1:0] pages);
            grant_t g;
            if (pending_grants.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            g = pending_grants.pop_front();
            if (id !== g.id)
                report_mismatch("granted_id", id, g.id);
            if (st !== g.st)
                report_mismatch("status", st, g.st);
            if (free_n !== g.free_n)
                report_mismatch("free_count", free_n, g.free_n);
            if (pages !== g.pages)
                report_mismatch("pages_used", pages, g.pages);
        endtask
    endclass

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                opcode     = OP_ALLOC;
    logic [ID_W-1:0]     page_id    = '0;
    logic                out_stall  = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_count;
    logic [COUNT_W-1:0]  pages_used;

    page_book    book;
    int unsigned burst_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;

    page_free_list_allocator #(
        .MAX_PAGES (MAX_PAGES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .page_id    (page_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .granted_id (granted_id),
        .status     (status),
        .free_count (free_count),
        .pages_used (pages_used)
    );

    always #10 clk = ~clk;

    // Send one request transaction; bursts of random length with random gaps.
    task automatic issue(input logic op, input logic [ID_W-1:0] id);
        if (burst_left == 0)
        begin
            if (in_valid)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        in_valid <= 1'b1;
        opcode   <= op;
        page_id  <= id;
        do
            @(posedge clk);
        while (in_stall);
        book.log_request(op, id);
    endtask

    // Receiver stall pattern: modes of random length, including no stall at all.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 128);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
        endcase
    end

    // Check every accepted result transaction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            book.check_grant(granted_id, status, free_count, pages_used);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        int unsigned     alloc_pct;
        logic            op;
        logic [ID_W-1:0] pick;

        book = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: growth, range errors, double free, list pop order.
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_FREE, 10'd0);
        issue(OP_FREE, 10'd1023);
        issue(OP_FREE, 10'd4);
        issue(OP_FREE, 10'd2);
        issue(OP_FREE, 10'd2);
        issue(OP_FREE, 10'd1);
        issue(OP_FREE, 10'd3);
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd1023);
        issue(OP_FREE, 10'd1);
        issue(OP_FREE, 10'd1);
        issue(OP_ALLOC, 10'd512);
        issue(OP_ALLOC, 10'd0);
        issue(OP_ALLOC, 10'd0);
        issue(OP_FREE, 10'd512);
        issue(OP_FREE, 10'd4);
        issue(OP_ALLOC, 10'd0);

        // Random: grow to capacity first, then mixes that fill and drain the list.
        alloc_pct = 95;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 0)
                alloc_pct = (book.total < COUNT_W'(MAX_PAGES)) ? 95
                                                               : 20 + 30 * $urandom_range(0, 2);
            op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
            case ($urandom_range(0, 9))
                0, 1:    pick = ID_W'($urandom_range(0, 1023));
                2:       pick = book.head;
                default: pick = (book.total > COUNT_W'(1))
                                ? ID_W'($urandom_range(1, int'(book.total) - 1)) : 10'd1;
            endcase
            if (op == OP_ALLOC)
                pick = ID_W'($urandom_range(0, 1023));
            issue(op, pick);
        end
        in_valid <= 1'b0;

        // Drain the outstanding results, then allow for stray extra ones.
        while (book.pending_grants.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY) @(posedge clk);
        if (book.mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
